>>> rtl/core/diff_drive_wheel_speed_desaturate_top_defines.svh
// assertion macros used by the wheel speed desaturation block
`ifndef DIFF_DRIVE_WHEEL_SPEED_DESATURATE_TOP_DEFINES_SVH
`define DIFF_DRIVE_WHEEL_SPEED_DESATURATE_TOP_DEFINES_SVH

// check a property on a named clock and active-low reset
`define DWSD_ASSERT_AT(lbl, clk_s, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) prop) else $error(msg);

// check a property on the usual clk and arst_n of the module
`define DWSD_ASSERT(lbl, prop, msg) `DWSD_ASSERT_AT(lbl, clk, arst_n, prop, msg)

`endif

>>> rtl/core/dwsd_pkg.sv
// types and constants of the wheel speed desaturation block
package dwsd_pkg;

	localparam int OUT_WIDTH = 16;
	localparam logic [31:0] OUT_MAX = 32'((64'd1 << (OUT_WIDTH - 1)) - 64'd1);

	// register file
	localparam int REG_IDX_W = 2;
	localparam int CFG_W     = 24;
	localparam logic [REG_IDX_W-1:0] REG_TRACK_WIDTH   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_RPM_PER_SPEED = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MAX_RPM       = 2'd2;

	localparam int TW_W   = 16;
	localparam int GAIN_W = 24;
	localparam int LIM_W  = 15;
	localparam int IN_W   = 24;

	localparam logic [TW_W-1:0]   TRACK_WIDTH_RST   = 16'd3072;
	localparam logic [GAIN_W-1:0] RPM_PER_SPEED_RST = 24'd385148;
	localparam logic [LIM_W-1:0]  MAX_RPM_RST       = 15'd600;

	// wheel speed datapath, units of 2^-25 in/s
	localparam int BASE_SHIFT = 17;
	localparam int TERM_W     = IN_W + TW_W + 1;
	localparam int SUM_W      = 42;
	localparam int MAG_W      = SUM_W - 1;
	localparam int SPLIT      = 21;
	localparam int HI_W       = MAG_W - SPLIT;
	localparam int GMAG_W     = GAIN_W;
	localparam int LO_PP_W    = SPLIT + GMAG_W;
	localparam int HI_PP_W    = HI_W + GMAG_W;
	localparam int FULL_W     = HI_PP_W + SPLIT;
	localparam int RPM_FRAC   = 25;
	localparam int Q16_W      = FULL_W - RPM_FRAC;
	localparam int RND_W      = Q16_W + 1 - 16;
	localparam int PROD_W     = Q16_W + LIM_W;
	localparam int BYP_W      = LIM_W;

	// desaturation divider
	localparam int QUO_W = 16;
	localparam int NUM_W = PROD_W + 2;
	localparam int DEN_W = Q16_W + 1;
	localparam int REM_W = NUM_W - QUO_W;

	// queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [TW_W-1:0]          track_width;
		logic signed [GAIN_W-1:0] rpm_per_speed;
		logic [LIM_W-1:0]         max_rpm;
	} cfg_t;

	typedef struct packed {
		logic              sc;
		logic              neg_l;
		logic              neg_r;
		logic [PROD_W-1:0] prod_l;
		logic [PROD_W-1:0] prod_r;
		logic [Q16_W-1:0]  maxabs;
		logic [BYP_W-1:0]  byp_l;
		logic [BYP_W-1:0]  byp_r;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

>>> rtl/core/dwsd_if.sv
// valid/ready channels carrying chassis commands in and motor commands out
interface dwsd_in_if;
	import dwsd_pkg::*;

	logic                   valid;
	logic                   ready;
	logic signed [IN_W-1:0] forward_speed;
	logic signed [IN_W-1:0] turn_rate;

	modport source (output valid, output forward_speed, output turn_rate, input ready);
	modport sink (input valid, input forward_speed, input turn_rate, output ready);
endinterface

interface dwsd_out_if;
	import dwsd_pkg::*;

	logic                        valid;
	logic                        ready;
	logic signed [OUT_WIDTH-1:0] left_cmd;
	logic signed [OUT_WIDTH-1:0] right_cmd;
	logic                        scaled;

	modport source (output valid, output left_cmd, output right_cmd, output scaled,
		input ready);
	modport sink (input valid, input left_cmd, input right_cmd, input scaled,
		output ready);
endinterface

>>> rtl/core/diff_drive_wheel_speed_desaturate_top.sv
// top level of the differential drive wheel speed block with desaturation
//
// channel   dir   handshake        payload
// in_ch     in    valid/ready      forward_speed, turn_rate
// out_ch    out   valid/ready      left_cmd, right_cmd, scaled
// cfg       in    cfg_we           cfg_index, cfg_data
//
// one item per cycle sustained while out_ch.ready holds; the path from acceptance to result
// valid runs through a 7-stage front pipeline and the 16-stage one-bit-per-stage divider.
// reset clears the valid bits and loads the register defaults; no clearing pass.
// a stalled output freezes the back end, the 2-entry queue fills, then in_ch.ready
// drops; the queue lets new items enter while a result waits.
module diff_drive_wheel_speed_desaturate_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dwsd_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [dwsd_pkg::CFG_W-1:0]    cfg_data,
	dwsd_in_if.sink                       in_ch,
	dwsd_out_if.source                    out_ch
);
	import dwsd_pkg::*;

	cfg_t     cfg_q;
	q_stat_t  qstat;
	q_entry_t push_entry;
	q_entry_t head;
	logic     push;
	logic     pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.track_width   <= TRACK_WIDTH_RST;
			cfg_q.rpm_per_speed <= RPM_PER_SPEED_RST;
			cfg_q.max_rpm       <= MAX_RPM_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TRACK_WIDTH: begin
					cfg_q.track_width <= cfg_data[TW_W-1:0];
				end
				REG_RPM_PER_SPEED: begin
					cfg_q.rpm_per_speed <= cfg_data[GAIN_W-1:0];
				end
				REG_MAX_RPM: begin
					cfg_q.max_rpm <= cfg_data[LIM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	dwsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_ch      (in_ch),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	dwsd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.stat       (qstat)
	);

	dwsd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.qstat  (qstat),
		.head   (head),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule

>>> rtl/core/dwsd_front.sv
// front pipeline: wheel speeds, gain products and desaturation classification
module dwsd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  dwsd_pkg::cfg_t     cfg,
	dwsd_in_if.sink            in_ch,
	input  dwsd_pkg::q_stat_t  qstat,
	output logic               push,
	output dwsd_pkg::q_entry_t push_entry
);
	import dwsd_pkg::*;

	logic              en;
	logic              gain_neg;
	logic [GMAG_W-1:0] gmag;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic signed [IN_W-1:0]   fs_s1;
	logic signed [TERM_W-1:0] term_s1;

	logic signed [SUM_W-1:0] sum_l_s2, sum_r_s2;

	logic [MAG_W-1:0] mag_l_s3, mag_r_s3;
	logic             neg_l_s3, neg_r_s3;

	logic [LO_PP_W-1:0] lo_l_s4, lo_r_s4;
	logic [HI_PP_W-1:0] hi_l_s4, hi_r_s4;
	logic               neg_l_s4, neg_r_s4;

	logic [Q16_W-1:0] q_l_s5, q_r_s5;
	logic             neg_l_s5, neg_r_s5;

	logic [Q16_W-1:0] q_l_s6, q_r_s6, maxabs_s6;
	logic [RND_W-1:0] byp_l_s6, byp_r_s6;
	logic             neg_l_s6, neg_r_s6;

	logic [FULL_W-1:0] full_l, full_r;
	logic [Q16_W:0]    rnd_l, rnd_r;
	logic [SUM_W-1:0]  base, termx;

	assign en       = !v_s7 || !qstat.full;
	assign in_ch.ready = en;
	assign push     = v_s7 && !qstat.full;

	assign gain_neg = cfg.rpm_per_speed[GAIN_W-1];
	assign gmag     = gain_neg ? (~cfg.rpm_per_speed + 1'b1) : cfg.rpm_per_speed;

	assign base  = {fs_s1[IN_W-1], fs_s1, {BASE_SHIFT{1'b0}}};
	assign termx = {term_s1[TERM_W-1], term_s1};

	// exact product reassembled, then half added for rounding to 2^-16 rpm
	assign full_l = {hi_l_s4, {SPLIT{1'b0}}} + FULL_W'(lo_l_s4)
		+ (FULL_W'(1) << (RPM_FRAC - 1));
	assign full_r = {hi_r_s4, {SPLIT{1'b0}}} + FULL_W'(lo_r_s4)
		+ (FULL_W'(1) << (RPM_FRAC - 1));

	assign rnd_l = {1'b0, q_l_s5} + (Q16_W + 1)'(32'h8000);
	assign rnd_r = {1'b0, q_r_s5} + (Q16_W + 1)'(32'h8000);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fs_s1   <= in_ch.forward_speed;
			term_s1 <= in_ch.turn_rate * $signed({1'b0, cfg.track_width});

			sum_l_s2 <= base - termx;
			sum_r_s2 <= base + termx;

			mag_l_s3 <= MAG_W'(sum_l_s2[SUM_W-1] ? -sum_l_s2 : sum_l_s2);
			mag_r_s3 <= MAG_W'(sum_r_s2[SUM_W-1] ? -sum_r_s2 : sum_r_s2);
			neg_l_s3 <= sum_l_s2[SUM_W-1] ^ gain_neg;
			neg_r_s3 <= sum_r_s2[SUM_W-1] ^ gain_neg;

			// magnitude split in two halves against the gain magnitude
			lo_l_s4  <= mag_l_s3[SPLIT-1:0] * gmag;
			hi_l_s4  <= mag_l_s3[MAG_W-1:SPLIT] * gmag;
			lo_r_s4  <= mag_r_s3[SPLIT-1:0] * gmag;
			hi_r_s4  <= mag_r_s3[MAG_W-1:SPLIT] * gmag;
			neg_l_s4 <= neg_l_s3;
			neg_r_s4 <= neg_r_s3;

			q_l_s5   <= full_l[FULL_W-1:RPM_FRAC];
			q_r_s5   <= full_r[FULL_W-1:RPM_FRAC];
			neg_l_s5 <= neg_l_s4;
			neg_r_s5 <= neg_r_s4;

			q_l_s6    <= q_l_s5;
			q_r_s6    <= q_r_s5;
			maxabs_s6 <= (q_l_s5 > q_r_s5) ? q_l_s5 : q_r_s5;
			byp_l_s6  <= rnd_l[Q16_W:16];
			byp_r_s6  <= rnd_r[Q16_W:16];
			neg_l_s6  <= neg_l_s5;
			neg_r_s6  <= neg_r_s5;

			push_entry.sc     <= maxabs_s6 > Q16_W'({cfg.max_rpm, 16'h0000});
			push_entry.neg_l  <= neg_l_s6;
			push_entry.neg_r  <= neg_r_s6;
			push_entry.prod_l <= q_l_s6 * cfg.max_rpm;
			push_entry.prod_r <= q_r_s6 * cfg.max_rpm;
			push_entry.maxabs <= maxabs_s6;
			push_entry.byp_l  <= (byp_l_s6 > RND_W'(cfg.max_rpm)) ? cfg.max_rpm
				: byp_l_s6[BYP_W-1:0];
			push_entry.byp_r  <= (byp_r_s6 > RND_W'(cfg.max_rpm)) ? cfg.max_rpm
				: byp_r_s6[BYP_W-1:0];
		end
	end

endmodule

>>> rtl/core/dwsd_queue.sv
// short queue decoupling the front pipeline from the divider back end
`include "diff_drive_wheel_speed_desaturate_top_defines.svh"

module dwsd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  dwsd_pkg::q_entry_t push_entry,
	input  logic               pop,
	output dwsd_pkg::q_entry_t head,
	output dwsd_pkg::q_stat_t  stat
);
	import dwsd_pkg::*;

	q_entry_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	function automatic logic [QPTR_W-1:0] ptr_next(logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = cnt_q == QCNT_W'(QDEPTH);
	assign stat.empty = cnt_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	`DWSD_ASSERT(a_no_overflow, !(push && stat.full), "beat pushed into full queue")
	`DWSD_ASSERT(a_no_underflow, !(pop && stat.empty), "beat popped from empty queue")
	`DWSD_ASSERT(a_cnt_range, cnt_q <= QCNT_W'(QDEPTH), "queue fill count out of range")
	`DWSD_ASSERT(a_fill_seen, (push && !pop && stat.empty) |=> !stat.empty, "pushed beat lost")

endmodule

>>> rtl/core/dwsd_back.sv
// back end: pipelined restoring divider for desaturation, output encode and register
module dwsd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  dwsd_pkg::cfg_t     cfg,
	input  dwsd_pkg::q_stat_t  qstat,
	input  dwsd_pkg::q_entry_t head,
	output logic               pop,
	dwsd_out_if.source         out_ch
);
	import dwsd_pkg::*;

	typedef struct packed {
		logic              sc;
		logic              neg_l;
		logic              neg_r;
		logic [REM_W-1:0]  rem_l;
		logic [REM_W-1:0]  rem_r;
		logic [QUO_W-1:0]  low_l;
		logic [QUO_W-1:0]  low_r;
		logic [QUO_W-1:0]  quo_l;
		logic [QUO_W-1:0]  quo_r;
		logic [DEN_W-1:0]  den;
		logic [BYP_W-1:0]  byp_l;
		logic [BYP_W-1:0]  byp_r;
	} div_stage_t;

	logic       en;
	logic       vld_s1;
	div_stage_t pre_s1;
	div_stage_t pre_d;
	logic       dvld_s [QUO_W];
	div_stage_t div_s  [QUO_W];
	div_stage_t div_d  [QUO_W];
	div_stage_t last;

	logic [NUM_W-1:0] num_l, num_r;

	logic                        out_vld_q;
	logic signed [OUT_WIDTH-1:0] left_q, right_q;
	logic                        scaled_q;

	// one quotient bit for each lane, shared denominator
	function automatic div_stage_t div_step(div_stage_t s);
		div_stage_t     o;
		logic [REM_W:0] tl;
		logic [REM_W:0] tr;
		o  = s;
		tl = {s.rem_l, s.low_l[QUO_W-1]};
		tr = {s.rem_r, s.low_r[QUO_W-1]};
		if (tl >= {1'b0, s.den}) begin
			o.rem_l = REM_W'(tl - {1'b0, s.den});
			o.quo_l = {s.quo_l[QUO_W-2:0], 1'b1};
		end else begin
			o.rem_l = tl[REM_W-1:0];
			o.quo_l = {s.quo_l[QUO_W-2:0], 1'b0};
		end
		if (tr >= {1'b0, s.den}) begin
			o.rem_r = REM_W'(tr - {1'b0, s.den});
			o.quo_r = {s.quo_r[QUO_W-2:0], 1'b1};
		end else begin
			o.rem_r = tr[REM_W-1:0];
			o.quo_r = {s.quo_r[QUO_W-2:0], 1'b0};
		end
		o.low_l = {s.low_l[QUO_W-2:0], 1'b0};
		o.low_r = {s.low_r[QUO_W-2:0], 1'b0};
		return o;
	endfunction

	// clamp to limit and output range, then apply sign
	function automatic logic signed [OUT_WIDTH-1:0] encode(logic [QUO_W-1:0] mag,
		logic neg, logic [LIM_W-1:0] lim);
		logic [QUO_W-1:0]     m;
		logic [OUT_WIDTH-1:0] ext;
		m = mag;
		if (m > QUO_W'(lim)) begin
			m = QUO_W'(lim);
		end
		if (32'(m) > OUT_MAX) begin
			m = OUT_MAX[QUO_W-1:0];
		end
		ext = OUT_WIDTH'(m);
		return neg ? -ext : ext;
	endfunction

	assign en  = !out_vld_q || out_ch.ready;
	assign pop = en && !qstat.empty;

	// rounded quotient: (2*l*lim + maxabs) / (2*maxabs)
	assign num_l = NUM_W'({head.prod_l, 1'b0}) + NUM_W'(head.maxabs);
	assign num_r = NUM_W'({head.prod_r, 1'b0}) + NUM_W'(head.maxabs);

	always_comb begin
		pre_d.sc    = head.sc;
		pre_d.neg_l = head.neg_l;
		pre_d.neg_r = head.neg_r;
		pre_d.rem_l = num_l[NUM_W-1:QUO_W];
		pre_d.rem_r = num_r[NUM_W-1:QUO_W];
		pre_d.low_l = num_l[QUO_W-1:0];
		pre_d.low_r = num_r[QUO_W-1:0];
		pre_d.quo_l = '0;
		pre_d.quo_r = '0;
		pre_d.den   = {head.maxabs, 1'b0};
		pre_d.byp_l = head.byp_l;
		pre_d.byp_r = head.byp_r;
	end

	always_comb begin
		for (int k = 0; k < QUO_W; k++) begin
			div_d[k] = div_step((k == 0) ? pre_s1 : div_s[(k == 0) ? 0 : k - 1]);
		end
	end

	assign last = div_s[QUO_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
			for (int k = 0; k < QUO_W; k++) begin
				dvld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s1    <= pop;
			dvld_s[0] <= vld_s1;
			for (int k = 1; k < QUO_W; k++) begin
				dvld_s[k] <= dvld_s[k-1];
			end
			out_vld_q <= dvld_s[QUO_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pre_s1 <= pre_d;
			for (int k = 0; k < QUO_W; k++) begin
				div_s[k] <= div_d[k];
			end
			left_q   <= encode(last.sc ? last.quo_l : QUO_W'(last.byp_l), last.neg_l,
				cfg.max_rpm);
			right_q  <= encode(last.sc ? last.quo_r : QUO_W'(last.byp_r), last.neg_r,
				cfg.max_rpm);
			scaled_q <= last.sc;
		end
	end

	assign out_ch.valid     = out_vld_q;
	assign out_ch.left_cmd  = left_q;
	assign out_ch.right_cmd = right_q;
	assign out_ch.scaled    = scaled_q;

endmodule
